### rtl/sat_pkg.sv
// Package for the self-alignment torque pipeline: shared types, register indexes
// and the Q16.16 arithmetic helpers. No dependencies.
package sat_pkg;

  localparam int WORD_W = 32;
  localparam int AXIS_W = 18;
  localparam int PROD_W = 48;
  localparam int AXP_W  = 35;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [63:0] HALF_LSB = 64'sd32768;
  localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

  localparam logic signed [AXIS_W-1:0] AXIS_ONE  = 18'sd65536;
  localparam logic signed [AXIS_W-1:0] AXIS_ZERO = 18'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_GAIN   = 3'd1,
    REG_AXIS_X = 3'd2,
    REG_AXIS_Y = 3'd3,
    REG_AXIS_Z = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    MODE_DIPOLE = 1'b0,
    MODE_QUAT   = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [WORD_W-1:0] gain;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
  } cfg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] z;
  } vec_t;

  // Per-item data that rides alongside the arithmetic.
  typedef struct packed {
    logic grp;
    logic last;
    vec_t vel;
    vec_t tq;
  } side_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [WORD_W-1:0] r;
    if (x > WORD_MAX) begin
      r = WORD_MAX[WORD_W-1:0];
    end else if (x < WORD_MIN) begin
      r = WORD_MIN[WORD_W-1:0];
    end else begin
      r = x[WORD_W-1:0];
    end
    return r;
  endfunction

  // Q16.16 product, rounded half up.
  function automatic logic signed [PROD_W-1:0] mulq(input logic signed [WORD_W-1:0] a,
                                                     input logic signed [WORD_W-1:0] b);
    logic signed [63:0] p;
    logic signed [63:0] r;
    p = 64'(a) * 64'(b);
    r = (p + HALF_LSB) >>> 16;
    return r[PROD_W-1:0];
  endfunction

  // Q16.16 word times Q16 axis component, rounded half up.
  function automatic logic signed [AXP_W-1:0] mulq_axis(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [AXIS_W-1:0] b);
    logic signed [63:0] p;
    logic signed [63:0] r;
    p = 64'(a) * 64'(b);
    r = (p + HALF_LSB) >>> 16;
    return r[AXP_W-1:0];
  endfunction

endpackage

### rtl/sat_if.sv
// Valid/ready channel interfaces for particle items and torque result items.
// No dependencies.
interface sat_in_if;
  logic               valid;
  logic               ready;
  logic               in_group;
  logic signed [31:0] orient_a;
  logic signed [31:0] orient_b;
  logic signed [31:0] orient_c;
  logic signed [31:0] orient_d;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] torque_in_x;
  logic signed [31:0] torque_in_y;
  logic signed [31:0] torque_in_z;
  logic               last_particle;

  modport source (output valid, in_group, orient_a, orient_b, orient_c, orient_d,
                  vel_x, vel_y, vel_z, torque_in_x, torque_in_y, torque_in_z,
                  last_particle, input ready);
  modport sink   (input valid, in_group, orient_a, orient_b, orient_c, orient_d,
                  vel_x, vel_y, vel_z, torque_in_x, torque_in_y, torque_in_z,
                  last_particle, output ready);
endinterface

interface sat_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] torque_out_x;
  logic signed [31:0] torque_out_y;
  logic signed [31:0] torque_out_z;
  logic               last_out;

  modport source (output valid, torque_out_x, torque_out_y, torque_out_z, last_out,
                  input ready);
  modport sink   (input valid, torque_out_x, torque_out_y, torque_out_z, last_out,
                  output ready);
endinterface

### rtl/sat_dir.sv
// Direction stages: quaternion products, rotation matrix, rotated axis and
// dipole/axis selection, four register stages. Depends on sat_pkg.
module sat_dir (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  sat_pkg::cfg_t                cfg,
  input  logic                         vld_i,
  input  sat_pkg::side_t               side_i,
  input  logic signed [31:0]           oa_i,
  input  logic signed [31:0]           ob_i,
  input  logic signed [31:0]           oc_i,
  input  logic signed [31:0]           od_i,
  output logic                         vld_o,
  output sat_pkg::side_t               side_o,
  output sat_pkg::vec_t                dir_o
);
  import sat_pkg::*;

  logic  v1_r, v2_r, v3_r, v4_r;
  side_t side1_r, side2_r, side3_r, side4_r;
  vec_t  o1_r, o2_r, o3_r;
  vec_t  dir_r;

  logic signed [PROD_W-1:0] w2_r, x2_r, y2_r, z2_r;
  logic signed [PROD_W-1:0] xy_r, xz_r, yz_r, xw_r, yw_r, zw_r;
  logic signed [WORD_W-1:0] m_r [3][3];
  logic signed [AXP_W-1:0]  p_r [3][3];

  logic signed [63:0] w2, x2, y2, z2, xy2, xz2, yz2, xw2, yw2, zw2;
  logic signed [AXIS_W-1:0] axis [3];
  logic signed [63:0] rsum [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage 1: the ten quaternion products.
  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_i;
      o1_r    <= '{x: oa_i, y: ob_i, z: oc_i};
      w2_r    <= mulq(oa_i, oa_i);
      x2_r    <= mulq(ob_i, ob_i);
      y2_r    <= mulq(oc_i, oc_i);
      z2_r    <= mulq(od_i, od_i);
      xy_r    <= mulq(ob_i, oc_i);
      xz_r    <= mulq(ob_i, od_i);
      yz_r    <= mulq(oc_i, od_i);
      xw_r    <= mulq(ob_i, oa_i);
      yw_r    <= mulq(oc_i, oa_i);
      zw_r    <= mulq(od_i, oa_i);
    end
  end

  // Stage 2: rotation matrix entries.
  always_comb begin
    w2  = 64'(w2_r);
    x2  = 64'(x2_r);
    y2  = 64'(y2_r);
    z2  = 64'(z2_r);
    xy2 = 64'(xy_r) <<< 1;
    xz2 = 64'(xz_r) <<< 1;
    yz2 = 64'(yz_r) <<< 1;
    xw2 = 64'(xw_r) <<< 1;
    yw2 = 64'(yw_r) <<< 1;
    zw2 = 64'(zw_r) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r   <= side1_r;
      o2_r      <= o1_r;
      m_r[0][0] <= sat32(w2 + x2 - y2 - z2);
      m_r[0][1] <= sat32(xy2 - zw2);
      m_r[0][2] <= sat32(yw2 + xz2);
      m_r[1][0] <= sat32(xy2 + zw2);
      m_r[1][1] <= sat32(w2 - x2 + y2 - z2);
      m_r[1][2] <= sat32(yz2 - xw2);
      m_r[2][0] <= sat32(xz2 - yw2);
      m_r[2][1] <= sat32(yz2 + xw2);
      m_r[2][2] <= sat32(w2 - x2 - y2 + z2);
    end
  end

  // Stage 3: matrix entries times the body axis.
  assign axis[0] = cfg.axis_x;
  assign axis[1] = cfg.axis_y;
  assign axis[2] = cfg.axis_z;

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side2_r;
      o3_r    <= o2_r;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_r[r][c] <= mulq_axis(m_r[r][c], axis[c]);
        end
      end
    end
  end

  // Stage 4: row sums, then the choice of direction.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] = 64'(p_r[r][0]) + 64'(p_r[r][1]) + 64'(p_r[r][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side3_r;
      if (cfg.mode == MODE_QUAT) begin
        dir_r <= '{x: sat32(rsum[0]), y: sat32(rsum[1]), z: sat32(rsum[2])};
      end else begin
        dir_r <= o3_r;
      end
    end
  end

  assign vld_o  = v4_r;
  assign side_o = side4_r;
  assign dir_o  = dir_r;

`ifndef SYNTHESIS
  a_dipole_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v3_r && cfg.mode == MODE_DIPOLE) |=> (dir_r == $past(o3_r)))
    else $error("dipole direction differs from the item's orientation");

  a_valid_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v3_r) |=> v4_r)
    else $error("item lost between matrix and direction stages");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(dir_r) && $stable(v4_r)))
    else $error("direction changed while the pipeline was stalled");
`endif

endmodule

### rtl/sat_torque.sv
// Torque stages: cross product with the velocity, gain scaling and saturated
// torque sum, four register stages ending in the output register. Depends on sat_pkg.
module sat_torque (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  sat_pkg::cfg_t      cfg,
  input  logic               vld_i,
  input  sat_pkg::side_t     side_i,
  input  sat_pkg::vec_t      dir_i,
  output logic               vld_o,
  output sat_pkg::vec_t      tq_o,
  output logic               last_o
);
  import sat_pkg::*;

  logic  v5_r, v6_r, v7_r, v8_r;
  side_t side5_r, side6_r, side7_r;
  vec_t  crs_r, tq_r;
  logic  last_r;

  logic signed [PROD_W-1:0] dyvz_r, dzvy_r, dzvx_r, dxvz_r, dxvy_r, dyvx_r;
  logic signed [PROD_W-1:0] gx_r, gy_r, gz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v5_r <= vld_i;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  // Stage 5: the six cross product terms.
  always_ff @(posedge clk) begin
    if (en) begin
      side5_r <= side_i;
      dyvz_r  <= mulq(dir_i.y, side_i.vel.z);
      dzvy_r  <= mulq(dir_i.z, side_i.vel.y);
      dzvx_r  <= mulq(dir_i.z, side_i.vel.x);
      dxvz_r  <= mulq(dir_i.x, side_i.vel.z);
      dxvy_r  <= mulq(dir_i.x, side_i.vel.y);
      dyvx_r  <= mulq(dir_i.y, side_i.vel.x);
    end
  end

  // Stage 6: cross product.
  always_ff @(posedge clk) begin
    if (en) begin
      side6_r <= side5_r;
      crs_r   <= '{x: sat32(64'(dyvz_r) - 64'(dzvy_r)),
                   y: sat32(64'(dzvx_r) - 64'(dxvz_r)),
                   z: sat32(64'(dxvy_r) - 64'(dyvx_r))};
    end
  end

  // Stage 7: gain.
  always_ff @(posedge clk) begin
    if (en) begin
      side7_r <= side6_r;
      gx_r    <= mulq(crs_r.x, cfg.gain);
      gy_r    <= mulq(crs_r.y, cfg.gain);
      gz_r    <= mulq(crs_r.z, cfg.gain);
    end
  end

  // Stage 8: saturated torque sum, or the torque unchanged outside the group.
  always_ff @(posedge clk) begin
    if (en) begin
      last_r <= side7_r.last;
      if (side7_r.grp) begin
        tq_r <= '{x: sat32(64'(side7_r.tq.x) + 64'(gx_r)),
                  y: sat32(64'(side7_r.tq.y) + 64'(gy_r)),
                  z: sat32(64'(side7_r.tq.z) + 64'(gz_r))};
      end else begin
        tq_r <= side7_r.tq;
      end
    end
  end

  assign vld_o  = v8_r;
  assign tq_o   = tq_r;
  assign last_o = last_r;

`ifndef SYNTHESIS
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v7_r && !side7_r.grp) |=> (tq_r == $past(side7_r.tq)))
    else $error("particle outside the group had its torque changed");

  a_last_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v7_r) |=> (last_r == $past(side7_r.last)))
    else $error("last flag not carried to the output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(tq_r) && $stable(v8_r)))
    else $error("output changed while stalled");
`endif

endmodule

### rtl/self_align_torque.sv
// Self-alignment torque, top level. Throughput: one item per cycle; the whole
// pipeline advances together, so it stalls only while the output register holds
// an item that has not been taken. Reset is synchronous: it empties the pipeline
// and sets the registers to dipole mode, zero gain and the x body axis.
// Depends on sat_pkg, sat_if, sat_dir and sat_torque.
module self_align_torque (
  input  logic                             clk,
  input  logic                             rst_n,
  sat_in_if.sink                           in_s,
  sat_out_if.source                        out_m,
  input  logic                             cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sat_pkg::WORD_W-1:0]       cfg_wdata
);
  import sat_pkg::*;

  cfg_t  cfg_r;
  logic  en;
  side_t side_in;
  logic  dir_vld;
  side_t dir_side;
  vec_t  dir;
  logic  out_vld;
  vec_t  tq_out;
  logic  last_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= MODE_DIPOLE;
      cfg_r.gain   <= '0;
      cfg_r.axis_x <= AXIS_ONE;
      cfg_r.axis_y <= AXIS_ZERO;
      cfg_r.axis_z <= AXIS_ZERO;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:   cfg_r.mode   <= mode_t'(cfg_wdata[0]);
        REG_GAIN:   cfg_r.gain   <= cfg_wdata;
        REG_AXIS_X: cfg_r.axis_x <= cfg_wdata[AXIS_W-1:0];
        REG_AXIS_Y: cfg_r.axis_y <= cfg_wdata[AXIS_W-1:0];
        REG_AXIS_Z: cfg_r.axis_z <= cfg_wdata[AXIS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign en         = out_m.ready || !out_vld;
  assign in_s.ready = en;

  assign side_in = '{grp:  in_s.in_group,
                     last: in_s.last_particle,
                     vel:  '{x: in_s.vel_x, y: in_s.vel_y, z: in_s.vel_z},
                     tq:   '{x: in_s.torque_in_x, y: in_s.torque_in_y,
                             z: in_s.torque_in_z}};

  sat_dir u_dir (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .cfg    (cfg_r),
    .vld_i  (in_s.valid),
    .side_i (side_in),
    .oa_i   (in_s.orient_a),
    .ob_i   (in_s.orient_b),
    .oc_i   (in_s.orient_c),
    .od_i   (in_s.orient_d),
    .vld_o  (dir_vld),
    .side_o (dir_side),
    .dir_o  (dir)
  );

  sat_torque u_torque (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .cfg    (cfg_r),
    .vld_i  (dir_vld),
    .side_i (dir_side),
    .dir_i  (dir),
    .vld_o  (out_vld),
    .tq_o   (tq_out),
    .last_o (last_out)
  );

  assign out_m.valid        = out_vld;
  assign out_m.torque_out_x = tq_out.x;
  assign out_m.torque_out_y = tq_out.y;
  assign out_m.torque_out_z = tq_out.z;
  assign out_m.last_out     = last_out;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_m.valid)
    else $error("result offered straight after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_m.valid |-> in_s.ready)
    else $error("input refused with an empty output register");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_m.valid && !out_m.ready) |=> (out_m.valid && $stable(out_m.torque_out_x)))
    else $error("stalled result dropped or changed");
`endif

endmodule
